// File: src/pmt_pkg.sv
`default_nettype none
package pmt_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SET    = 2'd1,
        OP_MOVE   = 2'd2,
        OP_MOVETO = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_NORM,
        S_SQ,
        S_SQRT,
        S_PROD,
        S_DIV,
        S_STEP,
        S_SNAP,
        S_OUT
    } t_state;

    localparam int R_W    = 30;   // normalized distance magnitude
    localparam int SPD_W  = 31;
    localparam int PROD_W = SPD_W + R_W;
    localparam int RAD_W  = 62;   // sum of three squares
    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0] LAST_MUL  = CNT_W'(3);
    localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(ROOT_W - 1);

    typedef struct packed {
        logic       load;
        logic       diff;
        logic       norm;
        logic       sq;
        logic       prod;
        logic       mul_en;
        logic       acc_en;
        logic [1:0] idx;
        logic       sqrt_step;
        logic       div_step;
        logic       step;
        logic       snap;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic at_target;
        logic norm_done;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// File: src/pmt_ctrl.sv
`default_nettype none
module pmt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pmt_pkg::t_stat i_stat,
    output pmt_pkg::t_cmd      o_cmd
);
    import pmt_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_stat.is_tick && !i_stat.at_target) ? S_DIFF : S_OUT;
                end
            end
            S_DIFF: n_state = S_NORM;
            S_NORM: begin
                if (i_stat.norm_done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (r_cnt == LAST_MUL) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_cnt == LAST_ITER) begin
                    n_state = S_PROD;
                end
            end
            S_PROD: begin
                if (r_cnt == LAST_MUL) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == LAST_ITER) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: n_state = S_SNAP;
            S_SNAP: n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (n_state != r_state) begin
            n_cnt = '0;
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_cmd.idx  = r_cnt[1:0];
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIFF: o_cmd.diff = 1'b1;
            S_NORM: o_cmd.norm = 1'b1;
            S_SQ: begin
                o_cmd.sq     = 1'b1;
                o_cmd.mul_en = (r_cnt != LAST_MUL);
                o_cmd.acc_en = (r_cnt != '0);
            end
            S_SQRT: o_cmd.sqrt_step = 1'b1;
            S_PROD: begin
                o_cmd.prod   = 1'b1;
                o_cmd.mul_en = (r_cnt != LAST_MUL);
                o_cmd.acc_en = (r_cnt != '0);
            end
            S_DIV:  o_cmd.div_step = 1'b1;
            S_STEP: o_cmd.step     = 1'b1;
            S_SNAP: o_cmd.snap     = 1'b1;
            S_OUT:  o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: src/pmt_dp.sv
`default_nettype none
module pmt_dp #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pmt_pkg::t_cmd      i_cmd,
    output pmt_pkg::t_stat          o_stat,
    input  wire logic [1:0]         i_opcode,
    input  wire logic signed [31:0] i_value_x,
    input  wire logic signed [31:0] i_value_y,
    input  wire logic signed [31:0] i_value_z,
    input  wire logic [30:0]        i_speed,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic                    o_at_target
);
    import pmt_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int MW = CW + 1;
    localparam int RW = (MW > R_W + 1) ? MW : R_W + 1;
    localparam int EW = CW + 33;
    localparam logic signed [EW-1:0] MAXV = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [EW-1:0] MINV = ~MAXV;
    localparam logic signed [EW-1:0] OMAX = {{(EW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [EW-1:0] OMIN = ~OMAX;

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] t;
        t = v;
        if (v > MAXV) t = MAXV;
        if (v < MINV) t = MINV;
        return t[CW-1:0];
    endfunction

    function automatic logic signed [31:0] sat_out(input logic signed [CW-1:0] p);
        logic signed [EW-1:0] t;
        t = EW'(p);
        if (t > OMAX) t = OMAX;
        if (t < OMIN) t = OMIN;
        return t[31:0];
    endfunction

    logic signed [CW-1:0]   r_pos [3];
    logic signed [CW-1:0]   r_tgt [3];
    logic [SPD_W-1:0]       r_spd;
    logic [RW-1:0]          r_mag [3];
    logic                   r_neg [3];
    logic [PROD_W-1:0]      r_prod;
    logic [RAD_W-1:0]       r_acc;
    logic [ROOT_W+1:0]      r_srem;
    logic [ROOT_W-1:0]      r_root;
    logic [SPD_W-1:0]       r_rem [3];
    logic [SPD_W-1:0]       r_lo  [3];
    logic [SPD_W-1:0]       r_q   [3];
    logic signed [31:0]     r_out_x, r_out_y, r_out_z;
    logic                   r_out_at, r_out_valid;

    logic signed [CW-1:0]   vin [3];
    logic                   at_tgt;
    logic                   norm_done;
    logic [SPD_W-1:0]       mul_a;
    logic [R_W-1:0]         mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [ROOT_W+3:0]      sq_t;
    logic [ROOT_W+3:0]      sq_trial;
    logic [ROOT_W-1:0]      len;
    logic [1:0]             prev_idx;

    assign vin[0] = sat_cw(EW'(i_value_x));
    assign vin[1] = sat_cw(EW'(i_value_y));
    assign vin[2] = sat_cw(EW'(i_value_z));

    assign at_tgt = (r_pos[0] == r_tgt[0]) && (r_pos[1] == r_tgt[1]) &&
                    (r_pos[2] == r_tgt[2]);
    // done once every magnitude fits in R_W bits
    assign norm_done = (r_mag[0][RW-1:R_W] == '0) && (r_mag[1][RW-1:R_W] == '0) &&
                       (r_mag[2][RW-1:R_W] == '0);

    assign o_stat.is_tick   = (i_opcode == OP_TICK);
    assign o_stat.at_target = at_tgt;
    assign o_stat.norm_done = norm_done;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // one shared multiplier: squares, then speed times distance
    always_comb begin
        mul_b = '0;
        case (i_cmd.idx)
            2'd0:    mul_b = r_mag[0][R_W-1:0];
            2'd1:    mul_b = r_mag[1][R_W-1:0];
            2'd2:    mul_b = r_mag[2][R_W-1:0];
            default: mul_b = '0;
        endcase
        mul_a = i_cmd.sq ? {1'b0, mul_b} : r_spd;
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign prev_idx = i_cmd.idx - 2'd1;

    // bit-pair square root step
    assign sq_t     = {r_srem, r_acc[RAD_W-1:RAD_W-2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign len      = (r_root == '0) ? ROOT_W'(1) : r_root;

    always_ff @(posedge i_clk) begin
        logic signed [MW-1:0] dd;
        logic signed [MW-1:0] ad;
        logic [SPD_W:0]       dt;
        logic signed [EW-1:0] ed;
        logic signed [EW-1:0] es;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_tgt[i] <= '0;
            end
            r_spd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                unique case (i_opcode)
                    OP_SET: begin
                        for (int i = 0; i < 3; i++) begin
                            r_pos[i] <= vin[i];
                            r_tgt[i] <= vin[i];
                        end
                    end
                    OP_MOVE: begin
                        for (int i = 0; i < 3; i++) begin
                            r_pos[i] <= sat_cw(EW'(r_pos[i]) + EW'(vin[i]));
                            r_tgt[i] <= sat_cw(EW'(r_tgt[i]) + EW'(vin[i]));
                        end
                    end
                    OP_MOVETO: begin
                        for (int i = 0; i < 3; i++) begin
                            r_tgt[i] <= vin[i];
                        end
                        r_spd <= i_speed;
                    end
                    OP_TICK: r_spd <= r_spd;
                endcase
            end
            if (i_cmd.step) begin
                for (int i = 0; i < 3; i++) begin
                    es = EW'($signed({1'b0, r_q[i]}));
                    r_pos[i] <= r_neg[i] ? sat_cw(EW'(r_pos[i]) - es)
                                         : sat_cw(EW'(r_pos[i]) + es);
                end
            end
            if (i_cmd.snap) begin
                es = EW'($signed({1'b0, r_spd}));
                for (int i = 0; i < 3; i++) begin
                    ed = EW'(r_tgt[i]) - EW'(r_pos[i]);
                    if (ed <= es && ed >= -es) begin
                        r_pos[i] <= r_tgt[i];
                    end
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // datapath scratch, no reset needed
        if (i_cmd.diff) begin
            for (int i = 0; i < 3; i++) begin
                dd = MW'(r_tgt[i]) - MW'(r_pos[i]);
                ad = dd[MW-1] ? -dd : dd;
                r_neg[i] <= dd[MW-1];
                r_mag[i] <= RW'($unsigned(ad));
            end
            r_acc  <= '0;
            r_srem <= '0;
            r_root <= '0;
            for (int i = 0; i < 3; i++) begin
                r_q[i] <= '0;
            end
        end
        if (i_cmd.norm && !norm_done) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= r_mag[i] >> 1;
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.sq && i_cmd.acc_en) begin
            r_acc <= r_acc + RAD_W'(r_prod);
        end
        if (i_cmd.prod && i_cmd.acc_en) begin
            case (prev_idx)
                2'd0: begin
                    r_rem[0] <= {1'b0, r_prod[PROD_W-1:SPD_W]};
                    r_lo[0]  <= r_prod[SPD_W-1:0];
                end
                2'd1: begin
                    r_rem[1] <= {1'b0, r_prod[PROD_W-1:SPD_W]};
                    r_lo[1]  <= r_prod[SPD_W-1:0];
                end
                2'd2: begin
                    r_rem[2] <= {1'b0, r_prod[PROD_W-1:SPD_W]};
                    r_lo[2]  <= r_prod[SPD_W-1:0];
                end
                default: r_rem[0] <= r_rem[0];
            endcase
        end
        if (i_cmd.sqrt_step) begin
            r_acc <= r_acc << 2;
            if (sq_t >= sq_trial) begin
                r_srem <= (ROOT_W+2)'(sq_t - sq_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_srem <= sq_t[ROOT_W+1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        // three restoring dividers sharing the length
        if (i_cmd.div_step) begin
            for (int i = 0; i < 3; i++) begin
                dt = {r_rem[i], r_lo[i][SPD_W-1]};
                r_lo[i] <= r_lo[i] << 1;
                if (dt >= {1'b0, len}) begin
                    r_rem[i] <= SPD_W'(dt - {1'b0, len});
                    r_q[i]   <= {r_q[i][SPD_W-2:0], 1'b1};
                end else begin
                    r_rem[i] <= dt[SPD_W-1:0];
                    r_q[i]   <= {r_q[i][SPD_W-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out_x  <= sat_out(r_pos[0]);
            r_out_y  <= sat_out(r_pos[1]);
            r_out_z  <= sat_out(r_pos[2]);
            r_out_at <= at_tgt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_pos_z     = r_out_z;
    assign o_at_target = r_out_at;

endmodule
`default_nettype wire

// File: src/point_move_toward_target_unit.sv
`default_nettype none
// Set, move and move-to requests, and a tick with position at target, skip the stepping states.
// A tick that steps first normalizes the distance magnitudes to 30 bits, then runs the 31-step
// square root and the 31-step divider before the step and the snap. One request at a time.
// Reset (synchronous, active low) clears position, target and speed to zero.
module point_move_toward_target_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_opcode,
    input  wire logic signed [31:0] i_value_x,
    input  wire logic signed [31:0] i_value_y,
    input  wire logic signed [31:0] i_value_z,
    input  wire logic [30:0]        i_speed,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic                    o_at_target
);
    import pmt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pmt_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_opcode    (i_opcode),
        .i_value_x   (i_value_x),
        .i_value_y   (i_value_y),
        .i_value_z   (i_value_z),
        .i_speed     (i_speed),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_at_target (o_at_target)
    );

endmodule
`default_nettype wire

// File: src/pmt_checker.sv
`default_nettype none
module pmt_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [31:0] o_pos_x,
    input wire logic signed [31:0] o_pos_y,
    input wire logic signed [31:0] o_pos_z,
    input wire logic               o_at_target
);

    // one request in flight: accept drops ready
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while busy");

    // a new result only comes from a busy cycle
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pos_x) &&
        $stable(o_pos_y) && $stable(o_pos_z) && $stable(o_at_target))
        else $error("stalled result changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not clear handshake");

endmodule

bind point_move_toward_target_unit pmt_checker u_pmt_checker (.*);
`default_nettype wire
